>>> src/rvm_pkg.sv
// Shared types and constants of the ring voter memory update unit.
package rvm_pkg;

	// Field widths
	localparam int W_FUNC   = 1;
	localparam int W_INDEX  = 10;
	localparam int W_DRAW   = 16;
	localparam int W_WEIGHT = 17;
	localparam int W_COUNT  = 11;
	localparam int W_CELL   = 2;
	localparam int W_ROUNDS = 32;
	localparam int W_CFG    = 17;
	localparam int W_CFG_IX = 1;

	// Item function codes
	localparam logic [W_FUNC-1:0] FUNC_LOAD   = 1'b0;
	localparam logic [W_FUNC-1:0] FUNC_UPDATE = 1'b1;

	// Configuration register indexes
	localparam logic [W_CFG_IX-1:0] CFG_MEM_WEIGHT = 1'b0;
	localparam logic [W_CFG_IX-1:0] CFG_CELL_COUNT = 1'b1;

	// Q16 unity and register reset values
	localparam logic [W_WEIGHT-1:0] Q16_ONE      = 17'd65536;
	localparam logic [W_WEIGHT-1:0] WEIGHT_RESET = 17'd32768;
	localparam logic [W_COUNT-1:0]  COUNT_RESET  = 11'd1024;

	// Cell values that count as consensus
	localparam logic [W_CELL-1:0] CELL_ALL_ZERO = 2'd0;
	localparam logic [W_CELL-1:0] CELL_ALL_ONE  = 2'd3;

	typedef struct packed {
		logic [W_FUNC-1:0]  func;
		logic [W_INDEX-1:0] cell_index;
		logic               init_bit;
		logic [W_DRAW-1:0]  random_draw;
	} item_t;

	typedef struct packed {
		logic [W_CELL-1:0]   cell_value;
		logic                round_done;
		logic                agreement;
		logic [W_ROUNDS-1:0] round_count;
		logic                index_error;
	} result_t;

endpackage

>>> src/rvm_if.sv
// Handshake channels for input items and result items.
interface rvm_item_if;
	logic                           valid;
	logic                           ready;
	logic [rvm_pkg::W_FUNC-1:0]     func;
	logic [rvm_pkg::W_INDEX-1:0]    cell_index;
	logic                           init_bit;
	logic [rvm_pkg::W_DRAW-1:0]     random_draw;

	modport source (output valid, func, cell_index, init_bit, random_draw, input ready);
	modport sink (input valid, func, cell_index, init_bit, random_draw, output ready);
endinterface

interface rvm_result_if;
	logic                           valid;
	logic                           ready;
	logic [rvm_pkg::W_CELL-1:0]     cell_value;
	logic                           round_done;
	logic                           agreement;
	logic [rvm_pkg::W_ROUNDS-1:0]   round_count;
	logic                           index_error;

	modport source (output valid, cell_value, round_done, agreement, round_count, index_error,
		input ready);
	modport sink (input valid, cell_value, round_done, agreement, round_count, index_error,
		output ready);
endinterface

>>> src/rvm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rvm_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port; a read in the same cycle sees old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/rvm_addr.sv
// Range check and ring neighbour address generation for one item.
module rvm_addr #(
	parameter int MAX_CELLS = 1024,
	localparam int IW = $clog2(MAX_CELLS)
) (
	input  logic [rvm_pkg::W_INDEX-1:0] cell_index,
	input  logic [rvm_pkg::W_COUNT-1:0] cell_count,
	input  logic                        bank,
	output logic                        index_error,
	output logic                        last,
	output logic [IW:0]                 left_addr,
	output logic [IW:0]                 right_addr,
	output logic [IW:0]                 self_addr
);

	localparam int NW = $clog2(MAX_CELLS + 1);
	localparam int XW = (NW > rvm_pkg::W_COUNT) ? NW : rvm_pkg::W_COUNT;

	logic [XW-1:0] idx_x;
	logic [XW-1:0] cnt_x;
	logic [XW-1:0] n_x;
	logic [XW-1:0] left_x;
	logic [XW-1:0] right_x;

	// Clamp the configured count into the supported range.
	always_comb begin
		idx_x = XW'(cell_index);
		cnt_x = XW'(cell_count);
		if (cnt_x < XW'(2)) begin
			n_x = XW'(2);
		end else if (cnt_x > XW'(MAX_CELLS)) begin
			n_x = XW'(MAX_CELLS);
		end else begin
			n_x = cnt_x;
		end
	end

	// Neighbours wrap round the ring.
	always_comb begin
		index_error = (idx_x >= n_x);
		last        = (idx_x == n_x - XW'(1));
		left_x      = (idx_x == '0) ? n_x - XW'(1) : idx_x - XW'(1);
		right_x     = last ? '0 : idx_x + XW'(1);
		left_addr   = {bank, left_x[IW-1:0]};
		right_addr  = {bank, right_x[IW-1:0]};
		self_addr   = {bank, idx_x[IW-1:0]};
	end

endmodule

>>> src/rvm_vote.sv
// Voting rule: new cell value from the neighbours, the weight and the draw.
module rvm_vote (
	input  logic [rvm_pkg::W_FUNC-1:0]   func,
	input  logic                         init_bit,
	input  logic [rvm_pkg::W_DRAW-1:0]   random_draw,
	input  logic [rvm_pkg::W_WEIGHT-1:0] mem_weight,
	input  logic [rvm_pkg::W_CELL-1:0]   left_cell,
	input  logic [rvm_pkg::W_CELL-1:0]   right_cell,
	input  logic [rvm_pkg::W_CELL-1:0]   self_cell,
	output logic [rvm_pkg::W_CELL-1:0]   cell_value
);

	localparam int TW = rvm_pkg::W_WEIGHT + 2;

	logic [rvm_pkg::W_WEIGHT-1:0] m;
	logic [rvm_pkg::W_WEIGHT-1:0] m_inv;
	logic [1:0]                   old_sum;
	logic [1:0]                   cur_sum;
	logic [TW-1:0]                thresh;
	logic [TW-1:0]                twice_r;
	logic                         new_bit;

	// Threshold mixes previous and current neighbour opinions by the weight.
	always_comb begin
		m       = (mem_weight > rvm_pkg::Q16_ONE) ? rvm_pkg::Q16_ONE : mem_weight;
		m_inv   = rvm_pkg::Q16_ONE - m;
		old_sum = 2'(left_cell[1]) + 2'(right_cell[1]);
		cur_sum = 2'(left_cell[0]) + 2'(right_cell[0]);
		thresh  = TW'(old_sum) * TW'(m_inv) + TW'(cur_sum) * TW'(m);
		twice_r = TW'({random_draw, 1'b0});
		new_bit = (twice_r <= thresh);
	end

	// A load sets both bits; an update shifts the current bit up.
	always_comb begin
		if (func == rvm_pkg::FUNC_LOAD) begin
			cell_value = {init_bit, init_bit};
		end else begin
			cell_value = {self_cell[0], new_bit};
		end
	end

endmodule

>>> src/ring_voter_model_memory_update_unit.sv
// Top level: ring voter model cell update with a memory of one round.
// An item is registered in stage one and its result in the output register, held while stalled.
// Throughput: one item per cycle unless the output stalls; an item reads three store copies.
// The store copies are written at one address per cycle and forwarded one write deep.
// Reset clears control state and the round count and restores the register defaults.
// The cell store is not cleared by reset; cells must be loaded before they are read.
module ring_voter_model_memory_update_unit #(
	parameter int MAX_CELLS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rvm_pkg::W_CFG_IX-1:0]  cfg_index,
	input  logic [rvm_pkg::W_CFG-1:0]     cfg_data,
	rvm_item_if.sink                      items,
	rvm_result_if.source                  results
);

	localparam int IW = $clog2(MAX_CELLS);
	// Each bank spans the full index space of IW bits, so the bank bit stays in range.
	localparam int DEPTH = 2 * (1 << IW);

	// Configuration registers
	logic [rvm_pkg::W_WEIGHT-1:0] mem_weight_q;
	logic [rvm_pkg::W_COUNT-1:0]  cell_count_q;

	// Round state
	logic                         bank_q;
	logic [rvm_pkg::W_ROUNDS-1:0] rounds_q;
	logic                         all_same_q;
	logic [rvm_pkg::W_CELL-1:0]   first_q;

	// Stage one
	logic                 s1_valid_s1;
	rvm_pkg::item_t       item_s1;
	logic                 err_s1;
	logic                 last_s1;
	logic [IW:0]          left_addr_s1;
	logic [IW:0]          right_addr_s1;
	logic [IW:0]          self_addr_s1;

	// Forwarding of the latest store write
	logic                       byp_valid_q;
	logic [IW:0]                byp_addr_q;
	logic [rvm_pkg::W_CELL-1:0] byp_data_q;

	// Output register
	logic             out_valid_q;
	rvm_pkg::result_t res_q;

	logic                         accept;
	logic                         fire;
	logic                         flip;
	logic                         bank_nxt;
	logic                         wr_en;
	logic [IW:0]                  wr_addr;
	rvm_pkg::item_t               item_in;
	logic                         err_in;
	logic                         last_in;
	logic [IW:0]                  left_addr_in;
	logic [IW:0]                  right_addr_in;
	logic [IW:0]                  self_addr_in;
	logic [rvm_pkg::W_CELL-1:0]   ram_left;
	logic [rvm_pkg::W_CELL-1:0]   ram_right;
	logic [rvm_pkg::W_CELL-1:0]   ram_self;
	logic [rvm_pkg::W_CELL-1:0]   left_cell;
	logic [rvm_pkg::W_CELL-1:0]   right_cell;
	logic [rvm_pkg::W_CELL-1:0]   self_cell;
	logic [rvm_pkg::W_CELL-1:0]   value;
	logic                         all_same_nxt;
	logic [rvm_pkg::W_CELL-1:0]   first_nxt;
	logic [rvm_pkg::W_ROUNDS-1:0] rounds_nxt;
	rvm_pkg::result_t             res_nxt;

	// Handshake control
	always_comb begin
		fire            = s1_valid_s1 && (!out_valid_q || results.ready);
		items.ready     = !s1_valid_s1 || fire;
		accept          = items.valid && items.ready;
		flip            = fire && !err_s1 && last_s1 &&
			(item_s1.func == rvm_pkg::FUNC_UPDATE);
		bank_nxt        = bank_q ^ flip;
		item_in.func        = items.func;
		item_in.cell_index  = items.cell_index;
		item_in.init_bit    = items.init_bit;
		item_in.random_draw = items.random_draw;
	end

	// Addresses are formed with the bank as it stands once the item ahead has finished.
	rvm_addr #(.MAX_CELLS(MAX_CELLS)) u_addr (
		.cell_index  (items.cell_index),
		.cell_count  (cell_count_q),
		.bank        (bank_nxt),
		.index_error (err_in),
		.last        (last_in),
		.left_addr   (left_addr_in),
		.right_addr  (right_addr_in),
		.self_addr   (self_addr_in)
	);

	// Store write: a load goes to the current bank, an update to the other.
	always_comb begin
		wr_en   = fire && !err_s1;
		wr_addr = (item_s1.func == rvm_pkg::FUNC_LOAD) ? self_addr_s1 :
			{~self_addr_s1[IW], self_addr_s1[IW-1:0]};
	end

	rvm_ram #(.WIDTH(rvm_pkg::W_CELL), .DEPTH(DEPTH)) u_ram_left (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (value),
		.re    (accept),
		.raddr (left_addr_in),
		.rdata (ram_left)
	);

	rvm_ram #(.WIDTH(rvm_pkg::W_CELL), .DEPTH(DEPTH)) u_ram_right (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (value),
		.re    (accept),
		.raddr (right_addr_in),
		.rdata (ram_right)
	);

	rvm_ram #(.WIDTH(rvm_pkg::W_CELL), .DEPTH(DEPTH)) u_ram_self (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (value),
		.re    (accept),
		.raddr (self_addr_in),
		.rdata (ram_self)
	);

	// A read issued in the cycle of a write to the same cell takes the written value.
	always_comb begin
		left_cell  = (byp_valid_q && byp_addr_q == left_addr_s1) ? byp_data_q : ram_left;
		right_cell = (byp_valid_q && byp_addr_q == right_addr_s1) ? byp_data_q : ram_right;
		self_cell  = (byp_valid_q && byp_addr_q == self_addr_s1) ? byp_data_q : ram_self;
	end

	rvm_vote u_vote (
		.func        (item_s1.func),
		.init_bit    (item_s1.init_bit),
		.random_draw (item_s1.random_draw),
		.mem_weight  (mem_weight_q),
		.left_cell   (left_cell),
		.right_cell  (right_cell),
		.self_cell   (self_cell),
		.cell_value  (value)
	);

	// Agreement tracking, round count and the result.
	always_comb begin
		if (item_s1.cell_index == '0) begin
			first_nxt    = value;
			all_same_nxt = 1'b1;
		end else begin
			first_nxt    = first_q;
			all_same_nxt = all_same_q && (value == first_q);
		end
		if (item_s1.func == rvm_pkg::FUNC_LOAD) begin
			rounds_nxt = '0;
		end else if (last_s1 && rounds_q != '1) begin
			rounds_nxt = rounds_q + 1'b1;
		end else begin
			rounds_nxt = rounds_q;
		end
		if (err_s1) begin
			res_nxt.cell_value  = '0;
			res_nxt.round_done  = 1'b0;
			res_nxt.agreement   = 1'b0;
			res_nxt.round_count = rounds_q;
			res_nxt.index_error = 1'b1;
		end else begin
			res_nxt.cell_value  = value;
			res_nxt.round_done  = last_s1;
			res_nxt.agreement   = last_s1 && all_same_nxt &&
				(first_nxt == rvm_pkg::CELL_ALL_ZERO || first_nxt == rvm_pkg::CELL_ALL_ONE);
			res_nxt.round_count = rounds_nxt;
			res_nxt.index_error = 1'b0;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_weight_q <= rvm_pkg::WEIGHT_RESET;
			cell_count_q <= rvm_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rvm_pkg::CFG_MEM_WEIGHT: begin
					mem_weight_q <= cfg_data[rvm_pkg::W_WEIGHT-1:0];
				end
				rvm_pkg::CFG_CELL_COUNT: begin
					cell_count_q <= cfg_data[rvm_pkg::W_COUNT-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Control state: valid flags, round state and the forwarding entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			bank_q      <= 1'b0;
			rounds_q    <= '0;
			all_same_q  <= 1'b1;
			first_q     <= '0;
			byp_valid_q <= 1'b0;
		end else begin
			if (items.ready) begin
				s1_valid_s1 <= items.valid;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				bank_q      <= bank_nxt;
				rounds_q    <= rounds_nxt;
				all_same_q  <= all_same_nxt;
				first_q     <= first_nxt;
				byp_valid_q <= 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1       <= item_in;
			err_s1        <= err_in;
			last_s1       <= last_in;
			left_addr_s1  <= left_addr_in;
			right_addr_s1 <= right_addr_in;
			self_addr_s1  <= self_addr_in;
		end
		if (wr_en) begin
			byp_addr_q <= wr_addr;
			byp_data_q <= value;
		end
		if (fire) begin
			res_q <= res_nxt;
		end
	end

	// Result channel
	always_comb begin
		results.valid       = out_valid_q;
		results.cell_value  = res_q.cell_value;
		results.round_done  = res_q.round_done;
		results.agreement   = res_q.agreement;
		results.round_count = res_q.round_count;
		results.index_error = res_q.index_error;
	end

	// A stalled stage-one item must hold until it moves on.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && !fire |=> s1_valid_s1 && $stable(item_s1))
		else $error("stage one item changed while stalled");

	// The bank flips only when an update finishes the last cell.
	a_bank_flip: assert property (@(posedge clk) disable iff (!arst_n)
		!flip |=> $stable(bank_q))
		else $error("bank flipped outside a round end");

	// The round count saturates and only a load clears it.
	a_rounds_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rounds_q == '1 && !(wr_en && item_s1.func == rvm_pkg::FUNC_LOAD) |=> rounds_q == '1)
		else $error("round count wrapped");

	// Agreement is reported only with a finished round and never with an index error.
	a_agree_done: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> !res_q.agreement || (res_q.round_done && !res_q.index_error))
		else $error("agreement without round end");

endmodule
